// ===== rtl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package m3i_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAT_W          = 32;
  localparam int MINOR_W        = 2 * MAT_W;
  localparam int DET_W          = MINOR_W + MAT_W + 1;
  localparam int REM_W          = DET_W + 1;
  localparam int Q_W            = MAT_W;
  localparam int NUM_W          = MINOR_W + 2 * FRAC_BITS;
  localparam int OVF_W          = DET_W + Q_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;
  localparam int N_ELEM         = 9;

  typedef logic signed [MAT_W-1:0]   elem_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic [DET_W-1:0]          dmag_t;
  typedef logic [MINOR_W-1:0]        mag_t;
  typedef logic [REM_W-1:0]          rem_t;
  typedef logic [Q_W-1:0]            quot_t;

  localparam elem_t SAT_MAX = {1'b0, {(MAT_W-1){1'b1}}};
  localparam elem_t SAT_MIN = {1'b1, {(MAT_W-1){1'b0}}};

  typedef struct packed {
    elem_t m_r0_c0;
    elem_t m_r0_c1;
    elem_t m_r0_c2;
    elem_t m_r1_c0;
    elem_t m_r1_c1;
    elem_t m_r1_c2;
    elem_t m_r2_c0;
    elem_t m_r2_c1;
    elem_t m_r2_c2;
  } in_t;

  typedef struct packed {
    elem_t inv_r0_c0;
    elem_t inv_r0_c1;
    elem_t inv_r0_c2;
    elem_t inv_r1_c0;
    elem_t inv_r1_c1;
    elem_t inv_r1_c2;
    elem_t inv_r2_c0;
    elem_t inv_r2_c1;
    elem_t inv_r2_c2;
    logic  singular;
    logic  saturated;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/m3i_cofactor.sv =====
// Cofactor stages: nine 2x2 minor products, then difference and sign.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cofactor import m3i_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   valid,
  input  elem_t  m [N_ELEM],
  output logic   cof_valid,
  output minor_t cof [N_ELEM],
  output elem_t  m_out [N_ELEM]
);

  logic   v1;
  minor_t pa [N_ELEM];
  minor_t pb [N_ELEM];
  elem_t  m1 [N_ELEM];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      cof_valid <= 1'b0;
    end else if (en) begin
      v1        <= valid;
      cof_valid <= v1;
    end
  end

  for (genvar k = 0; k < N_ELEM; k++) begin : g_minor
    localparam int R  = k / 3;
    localparam int C  = k % 3;
    localparam int R1 = (R == 0) ? 1 : 0;
    localparam int R2 = (R == 2) ? 1 : 2;
    localparam int C1 = (C == 0) ? 1 : 0;
    localparam int C2 = (C == 2) ? 1 : 2;
    minor_t mn;

    assign mn = pa[k] - pb[k];

    always_ff @(posedge clk) begin
      if (en) begin
        pa[k]    <= minor_t'(m[R1*3+C1]) * minor_t'(m[R2*3+C2]);
        pb[k]    <= minor_t'(m[R1*3+C2]) * minor_t'(m[R2*3+C1]);
        m1[k]    <= m[k];
        cof[k]   <= ((R + C) % 2 == 1) ? -mn : mn;
        m_out[k] <= m1[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3i_det.sv =====
// Determinant stages: row 0 expanded along its cofactors, 64x32 products
// split into two partial products, then summed. Depends on m3i_pkg.
`default_nettype none

module m3i_det import m3i_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   valid,
  input  minor_t cof [N_ELEM],
  input  elem_t  m [N_ELEM],
  output logic   det_valid,
  output det_t   det,
  output minor_t cof_out [N_ELEM]
);

  logic                      v3;
  logic signed [MINOR_W-1:0] phi [3];
  logic signed [MINOR_W:0]   plo [3];
  minor_t                    cof3 [N_ELEM];
  det_t                      sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      det_valid <= 1'b0;
    end else if (en) begin
      v3        <= valid;
      det_valid <= v3;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_part
    always_ff @(posedge clk) begin
      if (en) begin
        phi[c] <= MINOR_W'($signed(cof[c][MINOR_W-1:MAT_W])) * MINOR_W'(m[c]);
        plo[c] <= (MINOR_W+1)'($signed({1'b0, cof[c][MAT_W-1:0]})) *
                  (MINOR_W+1)'(m[c]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      sum = sum + (DET_W'(phi[c]) <<< MAT_W) + DET_W'(plo[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cof3    <= cof;
      cof_out <= cof3;
      det     <= sum;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3i_div_lane.sv =====
// One pipelined restoring divider lane: |adj| * 2^(2F) / |det|, BITS_PER_STAGE
// quotient bits per stage, with an up-front overflow test. Depends on m3i_pkg.
`default_nettype none

module m3i_div_lane import m3i_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mag_t  amag,
  input  dmag_t dmag,
  input  logic  neg,
  output quot_t quot,
  output logic  ovf,
  output logic  neg_out
);

  logic [NUM_W-1:0] num;
  logic [OVF_W-1:0] lhs;
  logic [OVF_W-1:0] rhs;

  rem_t  rem  [DIV_STAGES+1];
  dmag_t d    [DIV_STAGES+1];
  quot_t q    [DIV_STAGES+1];
  quot_t low  [DIV_STAGES+1];
  logic  o    [DIV_STAGES+1];
  logic  n    [DIV_STAGES+1];

  assign num = {amag, {(2*FRAC_BITS){1'b0}}};
  assign lhs = OVF_W'(num);
  assign rhs = {dmag, {Q_W{1'b0}}};

  // quotient >= 2^32 exactly when num >= dmag * 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= REM_W'(num[NUM_W-1:Q_W]);
      low[0] <= num[Q_W-1:0];
      d[0]   <= dmag;
      q[0]   <= '0;
      o[0]   <= (lhs >= rhs);
      n[0]   <= neg;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    rem_t  r_n;
    rem_t  t;
    quot_t q_n;
    quot_t l_n;

    always_comb begin
      r_n = rem[s];
      q_n = q[s];
      l_n = low[s];
      t   = '0;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t   = {r_n[REM_W-2:0], l_n[Q_W-1]};
        l_n = {l_n[Q_W-2:0], 1'b0};
        if (t >= {1'b0, d[s]}) begin
          t   = t - {1'b0, d[s]};
          q_n = {q_n[Q_W-2:0], 1'b1};
        end else begin
          q_n = {q_n[Q_W-2:0], 1'b0};
        end
        r_n = t;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= r_n;
        q[s+1]   <= q_n;
        low[s+1] <= l_n;
        d[s+1]   <= d[s];
        o[s+1]   <= o[s];
        n[s+1]   <= n[s];
      end
    end
  end

  assign quot    = q[DIV_STAGES];
  assign ovf     = o[DIV_STAGES];
  assign neg_out = n[DIV_STAGES];

endmodule

`default_nettype wire

// ===== rtl/matrix3x3_inverse_unit.sv =====
// Top level of the 3x3 Q16.16 matrix inverse pipeline.
// Depends on m3i_pkg, m3i_cofactor, m3i_det and m3i_div_lane.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one matrix per transfer;
//   output channel out_valid/out_stall/out_data carries the nine inverse
//   elements plus the singular and saturated flags.
//   Throughput is one matrix per cycle while in_stall is low, set by the
//   fully pipelined dividers (nine lanes, two quotient bits per stage, 16 stages).
//   From input transfer to out_valid a matrix passes two cofactor stages,
//   two determinant stages, one magnitude stage, 17 divider stages and
//   the output register.
//   A zero determinant gives singular = 1 with the input matrix echoed.
//   Out-of-range elements clip to the Q16.16 limits and set saturated.
//   Reset (synchronous) empties the pipeline and the output registers.
//   When the receiver stalls, one more result lands in a skid register and
//   the pipeline then freezes; in_stall follows the skid register only.
`default_nettype none

module matrix3x3_inverse_unit import m3i_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int ECHO_D = 5 + DIV_STAGES + 1;

  logic   en;
  elem_t  m_in [N_ELEM];
  logic   cof_valid;
  minor_t cof [N_ELEM];
  elem_t  m2 [N_ELEM];
  logic   det_valid;
  det_t   det;
  minor_t cof4 [N_ELEM];

  logic   v5;
  logic   zero5;
  dmag_t  dmag5;
  mag_t   amag5 [N_ELEM];
  logic   neg5 [N_ELEM];

  logic   vd [DIV_STAGES+1];
  logic   sd [DIV_STAGES+1];
  in_t    echo [ECHO_D];

  quot_t  quot [N_ELEM];
  logic   ovf [N_ELEM];
  logic   negq [N_ELEM];
  elem_t  res [N_ELEM];
  logic   clip [N_ELEM];
  logic   any_clip;
  out_t   fin;
  logic   fin_v;

  logic   skid_v;
  out_t   skid_data;
  logic   out_free;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  assign m_in[0] = in_data.m_r0_c0;
  assign m_in[1] = in_data.m_r0_c1;
  assign m_in[2] = in_data.m_r0_c2;
  assign m_in[3] = in_data.m_r1_c0;
  assign m_in[4] = in_data.m_r1_c1;
  assign m_in[5] = in_data.m_r1_c2;
  assign m_in[6] = in_data.m_r2_c0;
  assign m_in[7] = in_data.m_r2_c1;
  assign m_in[8] = in_data.m_r2_c2;

  m3i_cofactor u_cof (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (in_valid),
    .m         (m_in),
    .cof_valid (cof_valid),
    .cof       (cof),
    .m_out     (m2)
  );

  m3i_det u_det (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (cof_valid),
    .cof       (cof),
    .m         (m2),
    .det_valid (det_valid),
    .det       (det),
    .cof_out   (cof4)
  );

  // magnitudes and quotient signs; lane r*3+c divides cofactor (c, r)
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= det_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero5 <= (det == '0);
      dmag5 <= det[DET_W-1] ? dmag_t'(-det) : dmag_t'(det);
    end
  end

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    localparam int R = k / 3;
    localparam int C = k % 3;

    always_ff @(posedge clk) begin
      if (en) begin
        amag5[k] <= cof4[C*3+R][MINOR_W-1] ? mag_t'(-cof4[C*3+R]) : mag_t'(cof4[C*3+R]);
        neg5[k]  <= cof4[C*3+R][MINOR_W-1] ^ det[DET_W-1];
      end
    end

    m3i_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .amag    (amag5[k]),
      .dmag    (dmag5),
      .neg     (neg5[k]),
      .quot    (quot[k]),
      .ovf     (ovf[k]),
      .neg_out (negq[k])
    );

    always_comb begin
      if (negq[k]) begin
        clip[k] = ovf[k] || (quot[k][Q_W-1] && (quot[k][Q_W-2:0] != '0));
        res[k]  = clip[k] ? SAT_MIN : elem_t'(-quot[k]);
      end else begin
        clip[k] = ovf[k] || quot[k][Q_W-1];
        res[k]  = clip[k] ? SAT_MAX : elem_t'(quot[k]);
      end
    end
  end

  // valid and singular flag travel alongside the dividers; the echo matrix is delayed from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_STAGES; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v5;
      for (int i = 1; i <= DIV_STAGES; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]   <= zero5;
      echo[0] <= in_data;
      for (int i = 1; i <= DIV_STAGES; i++) sd[i] <= sd[i-1];
      for (int i = 1; i < ECHO_D; i++) echo[i] <= echo[i-1];
    end
  end

  always_comb begin
    any_clip = 1'b0;
    for (int k = 0; k < N_ELEM; k++) any_clip = any_clip | clip[k];
  end

  always_comb begin
    fin_v = vd[DIV_STAGES];
    if (sd[DIV_STAGES]) begin
      fin.inv_r0_c0 = echo[ECHO_D-1].m_r0_c0;
      fin.inv_r0_c1 = echo[ECHO_D-1].m_r0_c1;
      fin.inv_r0_c2 = echo[ECHO_D-1].m_r0_c2;
      fin.inv_r1_c0 = echo[ECHO_D-1].m_r1_c0;
      fin.inv_r1_c1 = echo[ECHO_D-1].m_r1_c1;
      fin.inv_r1_c2 = echo[ECHO_D-1].m_r1_c2;
      fin.inv_r2_c0 = echo[ECHO_D-1].m_r2_c0;
      fin.inv_r2_c1 = echo[ECHO_D-1].m_r2_c1;
      fin.inv_r2_c2 = echo[ECHO_D-1].m_r2_c2;
      fin.singular  = 1'b1;
      fin.saturated = 1'b0;
    end else begin
      fin.inv_r0_c0 = res[0];
      fin.inv_r0_c1 = res[1];
      fin.inv_r0_c2 = res[2];
      fin.inv_r1_c0 = res[3];
      fin.inv_r1_c1 = res[4];
      fin.inv_r1_c2 = res[5];
      fin.inv_r2_c0 = res[6];
      fin.inv_r2_c1 = res[7];
      fin.inv_r2_c2 = res[8];
      fin.singular  = 1'b0;
      fin.saturated = any_clip;
    end
  end

  // output register plus one skid entry
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_free) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (fin_v) begin
      if (out_free) out_valid <= 1'b1;
      else skid_v <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_free) out_data <= skid_data;
    end else if (fin_v) begin
      if (out_free) out_data <= fin;
      else skid_data <= fin;
    end
  end

  a_sing_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.singular && out_data.saturated))
    else $error("singular result flagged saturated");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_v && out_stall |=> skid_v && $stable(skid_data))
    else $error("skid entry lost under stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && !out_stall |=> !skid_v && out_valid && out_data == $past(skid_data))
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire
